### sv/acd_pkg.sv
package acd_pkg;

  localparam int SAMPLES_PER_CHUNK = 28;
  localparam int NUM_FILTERS       = 5;

  localparam logic [7:0] END_FLAG   = 8'd7;
  localparam logic [4:0] LAST_INDEX = 5'(SAMPLES_PER_CHUNK - 1);

  // data nibbles of one chunk
  localparam int DATA_W = 4 * SAMPLES_PER_CHUNK;

  // history entry: recent in the low half, older in the high half
  localparam int HIST_W  = 32;
  localparam int ENTRY_W = 2 * HIST_W;

  typedef logic signed [7:0]        coef_t;
  typedef logic signed [HIST_W-1:0] hist_t;

  // filter coefficients in sixty-fourths
  localparam coef_t COEF_A [NUM_FILTERS] = '{8'sd0, 8'sd60, 8'sd115, 8'sd98, 8'sd122};
  localparam coef_t COEF_B [NUM_FILTERS] = '{8'sd0, 8'sd0, -8'sd52, -8'sd55, -8'sd60};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  // filter index above the table falls back to filter 0
  function automatic logic [2:0] filter_sel(input logic [3:0] p);
    logic [2:0] f;
    f = (p > 4'(NUM_FILTERS - 1)) ? 3'd0 : p[2:0];
    return f;
  endfunction

endpackage

### sv/adpcm_chunk_decoder_unit.sv
// ADPCM chunk decoder (SPU style), 28 samples per 16-byte chunk.
// Input stream (s_*): one item per chunk. s_tdata carries channel, predictor,
// shift and the 14 data bytes; s_tuser carries the flag byte.
// Output stream (m_*): one item per decoded sample, in order 0..27, with
// m_tlast on sample 27. An end chunk (flag byte 7) yields a single item with
// sample 0, index 0, m_tuser set and m_tlast set; history is left alone.
// Per-channel history (two Q19.12 values) sits in a small RAM with a registered
// read; each chunk reads its entry once, and a data chunk writes it back with
// the step that produces sample 27.
// Timing: a chunk is taken in the idle state, then comes the history read state,
// then one sample per cycle while the receiver keeps up. Each sample passes
// through the pending stage and then the output register.
// A stalled receiver holds the output register and one pending sample behind
// it; the filter recurrence simply pauses. The next chunk is accepted while the
// last samples of the previous one still drain.
// Reset: all history reads as zero (per-entry valid bits cleared), no output.
module adpcm_chunk_decoder_unit #(
  parameter int CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst,
  // s_tdata, low bit up: channel[2:0], predictor[3:0], shift[3:0],
  // data_low[55:0], data_high[55:0], zero pad[4:0]
  input  logic [127:0] s_tdata,
  // s_tuser: chunk_flags[7:0]
  input  logic [7:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // m_tdata, low bit up: out_channel[2:0], sample[15:0], sample_index[4:0]
  output logic [23:0]  m_tdata,
  // m_tuser: end_marker
  output logic [0:0]   m_tuser,
  output logic         m_tlast,
  output logic         m_tvalid,
  input  logic         m_tready
);

  import acd_pkg::*;

  localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // channel folded onto the history entries, repeated subtract on 5 bits
  function automatic logic [SLOT_W-1:0] chan_slot(input logic [2:0] ch);
    logic [4:0] c;
    c = {2'b00, ch};
    for (int i = 0; i < 8; i++) begin
      if (c >= 5'(CHANNELS)) begin
        c = c - 5'(CHANNELS);
      end
    end
    return c[SLOT_W-1:0];
  endfunction

  // ---------------------------------------------------------------- control
  state_t state;
  state_t state_next;

  logic s_accept;
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;

  // chunk registers
  logic [2:0]        chan;
  logic [SLOT_W-1:0] slot;
  logic [3:0]        shift;
  coef_t             k0;
  coef_t             k1;
  logic              is_end;
  logic [DATA_W-1:0] data;
  logic [4:0]        idx;
  logic              rd_valid;

  // filter history in flight
  hist_t recent;
  hist_t older;

  // pending sample between the filter and the output register
  logic       pend_valid;
  hist_t      pend_nv;
  logic [2:0] pend_chan;
  logic [4:0] pend_idx;
  logic       pend_end;
  logic       pend_last;

  logic pend_move;
  logic step_go;
  logic chunk_done;

  assign pend_move  = pend_valid && (!m_tvalid || m_tready);
  assign step_go    = (state == S_RUN) && (!pend_valid || pend_move);
  assign chunk_done = step_go && (is_end || (idx == LAST_INDEX));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) state_next = S_READ;
      end
      S_READ: state_next = S_RUN;
      S_RUN: begin
        if (chunk_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------------------------ history RAM
  logic [CHANNELS-1:0] hist_valid;
  logic [SLOT_W-1:0]   rd_slot;
  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  assign rd_slot = chan_slot(s_tdata[2:0]);

  acd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (ram_wdata),
    .re    (s_accept),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
    end else if (ram_we) begin
      hist_valid[slot] <= 1'b1;
    end
  end

  // ------------------------------------------------------------- filter step
  logic [3:0]         nib;
  logic signed [15:0] raw;
  logic signed [39:0] prod_a;
  logic signed [39:0] prod_b;
  logic signed [41:0] acc;
  logic signed [35:0] nv_wide;
  hist_t              nv;

  assign nib    = data[3:0];
  assign raw    = $signed({nib, 12'h000}) >>> shift;
  assign prod_a = k0 * recent;
  assign prod_b = k1 * older;
  assign acc    = {{8{raw[15]}}, raw, 18'h00000}
                + {{2{prod_a[39]}}, prod_a}
                + {{2{prod_b[39]}}, prod_b};
  assign nv_wide = acc[41:6];   // floor of acc / 64

  always_comb begin
    if (nv_wide[35:31] == 5'b00000 || nv_wide[35:31] == 5'b11111) begin
      nv = nv_wide[31:0];
    end else if (nv_wide[35]) begin
      nv = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      nv = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  assign ram_we    = step_go && !is_end && (idx == LAST_INDEX);
  assign ram_wdata = {recent, nv};

  always_ff @(posedge clk) begin
    if (s_accept) begin
      chan     <= s_tdata[2:0];
      slot     <= rd_slot;
      k0       <= COEF_A[filter_sel(s_tdata[6:3])];
      k1       <= COEF_B[filter_sel(s_tdata[6:3])];
      shift    <= s_tdata[10:7];
      data     <= s_tdata[11 +: DATA_W];
      is_end   <= (s_tuser == END_FLAG);
      rd_valid <= hist_valid[rd_slot];
    end
    if (state == S_READ) begin
      recent <= rd_valid ? hist_t'(ram_rdata[HIST_W-1:0]) : '0;
      older  <= rd_valid ? hist_t'(ram_rdata[ENTRY_W-1:HIST_W]) : '0;
    end else if (step_go && !is_end) begin
      recent <= nv;
      older  <= recent;
      data   <= {4'h0, data[DATA_W-1:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (s_accept || chunk_done) begin
      idx <= '0;
    end else if (step_go) begin
      idx <= idx + 5'd1;
    end
  end

  // ---------------------------------------------------------- pending stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (step_go) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      pend_nv   <= is_end ? '0 : nv;
      pend_chan <= chan;
      pend_idx  <= is_end ? 5'd0 : idx;
      pend_end  <= is_end;
      pend_last <= chunk_done;
    end
  end

  // ------------------------------------------ rounding and output register
  logic [32:0]        mag;
  logic [32:0]        mag_rnd;
  logic [20:0]        rnd;
  logic signed [15:0] smp;

  assign mag     = pend_nv[31] ? (33'd0 - {pend_nv[31], pend_nv}) : {1'b0, pend_nv};
  assign mag_rnd = mag + 33'd2048;
  assign rnd     = mag_rnd[32:12];

  always_comb begin
    if (!pend_nv[31]) begin
      smp = (rnd > 21'd32767) ? 16'sh7FFF : 16'(rnd);
    end else begin
      smp = (rnd > 21'd32768) ? 16'sh8000 : 16'(21'd0 - rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      m_tdata <= {pend_idx, smp, pend_chan};
      m_tuser <= pend_end;
      m_tlast <= pend_last;
    end
  end

  // -------------------------------------------------------------- checks
  a_wb_last_only: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_RUN) && (idx == LAST_INDEX) && !is_end)
    else $error("history written back before the final sample");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (idx <= LAST_INDEX))
    else $error("sample index ran past the chunk");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    chunk_done |=> (state == S_IDLE) && pend_valid && pend_last)
    else $error("chunk end not followed by idle with last sample pending");

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !pend_move) |=> pend_valid && $stable(pend_nv) && $stable(pend_idx))
    else $error("pending sample lost while output stalled");

endmodule

### sv/acd_ram.sv
module acd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
